@@ rtl/ptc_pkg.sv @@
package ptc_pkg;

  // Field and register widths
  localparam int ANGLE_W = 16;
  localparam int ACC_W = 48;
  localparam int GAIN_W = 16;
  localparam int TIME_W = 16;
  localparam int DRIVE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Derived datapath widths
  localparam int ERR_W = ANGLE_W + 1;
  localparam int ESUM_W = ERR_W + 1;
  localparam int MA_W = GAIN_W + ESUM_W;
  localparam int MB_W = GAIN_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int I_SHIFT = 17;
  localparam int INC_W = PROD_W - I_SHIFT;
  localparam int D_SCALE = 16;
  localparam int NUM_W = MA_W + D_SCALE;
  localparam int SUM_W = NUM_W + 2;
  localparam int ONE_SHIFT = 20;
  localparam int OUT_SHIFT = 6;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX =
    DRIVE_W'(longint'(1) << (ONE_SHIFT - OUT_SHIFT));
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -DRIVE_MAX;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = CFG_IDX_W'(3);

  // Microprogram steps
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE = step_t'(0);
  localparam step_t S_MUL_P = step_t'(1);
  localparam step_t S_MUL_X = step_t'(2);
  localparam step_t S_MUL_XT = step_t'(3);
  localparam step_t S_MUL_M = step_t'(4);
  localparam step_t S_DIV_INIT = step_t'(5);
  localparam step_t S_DIV_LOOP = step_t'(6);
  localparam step_t S_SUM = step_t'(7);
  localparam step_t S_EMIT = step_t'(8);
  localparam step_t S_LAST = S_EMIT;

  typedef enum logic [1:0] {A_ERR, A_ESUM, A_PROD, A_DIFF} a_sel_t;
  typedef enum logic [1:0] {B_GP, B_GI, B_GD, B_TIME} b_sel_t;
  typedef enum logic [1:0] {C_NEVER, C_NO_INPUT, C_DIV_MORE, C_OUT_FULL} cond_t;

  // One control word of the microprogram
  typedef struct packed {
    logic accept;
    logic mul_en;
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic ld_p;
    logic ld_integ;
    logic ld_neg;
    logic div_start;
    logic div_step;
    logic ld_sum;
    logic emit;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Status fed back to the sequencer for conditional jumps
  typedef struct packed {
    logic no_input;
    logic div_more;
    logic out_full;
  } stat_t;

  // Control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.accept = 1'b1;
        w.cond = C_NO_INPUT;
        w.target = S_IDLE;
      end
      S_MUL_P: begin
        w.mul_en = 1'b1;
        w.a_sel = A_ERR;
        w.b_sel = B_GP;
      end
      S_MUL_X: begin
        w.mul_en = 1'b1;
        w.a_sel = A_ESUM;
        w.b_sel = B_GI;
        w.ld_p = 1'b1;
      end
      S_MUL_XT: begin
        w.mul_en = 1'b1;
        w.a_sel = A_PROD;
        w.b_sel = B_TIME;
      end
      S_MUL_M: begin
        w.mul_en = 1'b1;
        w.a_sel = A_DIFF;
        w.b_sel = B_GD;
        w.ld_integ = 1'b1;
        w.ld_neg = 1'b1;
      end
      S_DIV_INIT: begin
        w.div_start = 1'b1;
      end
      S_DIV_LOOP: begin
        w.div_step = 1'b1;
        w.cond = C_DIV_MORE;
        w.target = S_DIV_LOOP;
      end
      S_SUM: begin
        w.ld_sum = 1'b1;
      end
      S_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OUT_FULL;
        w.target = S_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/ptc_sequencer.sv @@
module ptc_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  ptc_pkg::stat_t stat,
  output ptc_pkg::ctrl_t ctrl
);
  import ptc_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  // Fetch the control word of the current step
  assign ctrl = ucode(step_r);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_NO_INPUT: take = stat.no_input;
      C_DIV_MORE: take = stat.div_more;
      C_OUT_FULL: take = stat.out_full;
      default:    take = 1'b0;
    endcase
  end

  // Jump, wrap at the end of the program, or advance
  always_comb begin
    if (take) begin
      step_nxt = ctrl.target;
    end else if (step_r == S_LAST) begin
      step_nxt = S_IDLE;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ rtl/ptc_divider.sv @@
module ptc_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      step,
  input  logic [ptc_pkg::NUM_W-1:0]  num,
  input  logic [ptc_pkg::TIME_W-1:0] den,
  output logic [ptc_pkg::NUM_W-1:0]  quo,
  output logic                      more
);
  import ptc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [TIME_W-1:0] rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   trial_sub;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign fits = trial >= {1'b0, den};

  assign quo = quo_r;
  assign more = cnt_r > CNT_W'(1);

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (step) begin
      rem_r <= fits ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  // Bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

@@ rtl/ptc_datapath.sv @@
module ptc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptc_pkg::ctrl_t                      ctrl,
  output ptc_pkg::stat_t                      stat,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  input  logic signed [ptc_pkg::ANGLE_W-1:0]   in_measured_angle,
  input  logic [ptc_pkg::TIME_W-1:0]           in_elapsed_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ptc_pkg::DRIVE_W-1:0]   out_drive,
  output logic                                out_clamped
);
  import ptc_pkg::*;

  localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(longint'(1) << ONE_SHIFT);
  localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Configuration registers
  logic signed [ANGLE_W-1:0] setpoint_r;
  logic [GAIN_W-1:0]         gain_p_r;
  logic [GAIN_W-1:0]         gain_i_r;
  logic [GAIN_W-1:0]         gain_d_r;

  // Controller state
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [ACC_W-1:0]   integ_r;

  // Working registers
  logic signed [ERR_W-1:0]   err_r;
  logic [TIME_W-1:0]         time_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [MA_W-1:0]    p_r;
  logic                      neg_r;
  logic signed [SUM_W-1:0]   sum_r;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_clamped_r;

  logic                      acc_go;
  logic                      emit_go;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [ESUM_W-1:0]  esum;
  logic signed [ESUM_W-1:0]  ediff;
  logic [ESUM_W-1:0]         ediff_mag;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [INC_W-1:0]   inc;
  logic signed [ACC_W:0]     isum;
  logic signed [ACC_W-1:0]   integ_nxt;
  logic [NUM_W-1:0]          div_num;
  logic [NUM_W-1:0]          div_quo;
  logic                      div_more;
  logic signed [SUM_W-1:0]   d_val;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic                      clamped_nxt;

  assign acc_go = ctrl.accept && in_valid;
  assign emit_go = ctrl.emit && (!out_valid_r || out_ready);

  assign stat.no_input = !in_valid;
  assign stat.div_more = div_more;
  assign stat.out_full = out_valid_r && !out_ready;

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT: setpoint_r <= cfg_wdata[ANGLE_W-1:0];
        REG_GAIN_P:   gain_p_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:   gain_i_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:   gain_d_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Error terms
  assign err_nxt = {setpoint_r[ANGLE_W-1], setpoint_r}
                 - {in_measured_angle[ANGLE_W-1], in_measured_angle};
  assign esum = {err_r[ERR_W-1], err_r} + {prev_err_r[ERR_W-1], prev_err_r};
  assign ediff = {err_r[ERR_W-1], err_r} - {prev_err_r[ERR_W-1], prev_err_r};
  assign ediff_mag = ediff[ESUM_W-1] ? -ediff : ediff;

  // Latch the input word; a zero time counts as one LSB
  always_ff @(posedge clk) begin
    if (acc_go) begin
      err_r <= err_nxt;
      time_r <= (in_elapsed_time == '0) ? TIME_W'(1) : in_elapsed_time;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    case (ctrl.a_sel)
      A_ERR:   mul_a = {{(MA_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      A_ESUM:  mul_a = {{(MA_W-ESUM_W){esum[ESUM_W-1]}}, esum};
      A_PROD:  mul_a = prod_r[MA_W-1:0];
      A_DIFF:  mul_a = {{(MA_W-ESUM_W){1'b0}}, ediff_mag};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_GP:    mul_b = {1'b0, gain_p_r};
      B_GI:    mul_b = {1'b0, gain_i_r};
      B_GD:    mul_b = {1'b0, gain_d_r};
      B_TIME:  mul_b = {{(MB_W-TIME_W){1'b0}}, time_r};
      default: mul_b = '0;
    endcase
  end

  // Multiply and register the product
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Hold the proportional term and the derivative sign
  always_ff @(posedge clk) begin
    if (ctrl.ld_p) begin
      p_r <= prod_r[MA_W-1:0];
    end
    if (ctrl.ld_neg) begin
      neg_r <= ediff[ESUM_W-1];
    end
  end

  // Integral increment is floor(x * t / 2^17); saturate the accumulator
  assign inc = prod_r[PROD_W-1:I_SHIFT];
  assign isum = {integ_r[ACC_W-1], integ_r}
              + {{(ACC_W+1-INC_W){inc[INC_W-1]}}, inc};

  always_comb begin
    if (isum[ACC_W] != isum[ACC_W-1]) begin
      integ_nxt = isum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      integ_nxt = isum[ACC_W-1:0];
    end
  end

  // Advance the controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_err_r <= '0;
    end else begin
      if (ctrl.ld_integ) begin
        integ_r <= integ_nxt;
      end
      if (ctrl.ld_sum) begin
        prev_err_r <= err_r;
      end
    end
  end

  // Derivative magnitude: floor(m * 2^16 / t), one quotient bit per step
  assign div_num = {prod_r[MA_W-1:0], {D_SCALE{1'b0}}};

  ptc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.div_start),
    .step  (ctrl.div_step),
    .num   (div_num),
    .den   (time_r),
    .quo   (div_quo),
    .more  (div_more)
  );

  // Sum P, I and D
  always_comb begin
    d_val = {{(SUM_W-NUM_W){1'b0}}, div_quo};
    if (neg_r) begin
      d_val = -d_val;
    end
    sum_nxt = {{(SUM_W-MA_W){p_r[MA_W-1]}}, p_r}
            + d_val
            + {{(SUM_W-ACC_W){integ_r[ACC_W-1]}}, integ_r};
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

  // Clamp to plus or minus one and scale to the drive format
  always_comb begin
    if (sum_r > POS_LIM) begin
      drive_nxt = DRIVE_MAX;
      clamped_nxt = 1'b1;
    end else if (sum_r < NEG_LIM) begin
      drive_nxt = DRIVE_MIN;
      clamped_nxt = 1'b1;
    end else begin
      drive_nxt = sum_r[OUT_SHIFT+DRIVE_W-1:OUT_SHIFT];
      clamped_nxt = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_drive_r <= drive_nxt;
      out_clamped_r <= clamped_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_clamped = out_clamped_r;

endmodule

@@ rtl/pid_tilt_controller.sv @@
// PID tilt controller with trapezoidal integral. Each input word (angle in
// Q3.12 rad, elapsed time in Q0.16 s) yields one output word: the drive
// command in Q1.14, clamped to +-1.0, and a flag set when the clamp acted.
// Gains are Q8.8, written with the setpoint through the cfg_ port while the
// block is idle; index 0 setpoint, 1 P, 2 I, 3 D, other indexes are ignored.
// A small microprogram steps one shared 34x17 multiplier through the P, I
// and D products and runs a serial divider for the derivative. A word
// passes through 7 control steps and a divider loop that yields its 50
// quotient bits, one per step, before the result is loaded; the loop is
// the longest part of the program. in_ready is high only at the idle step,
// which comes again once the result has been loaded; a finished result
// waits in the output register while the next word is accepted and worked
// on; a result is held back only if the previous one is not yet taken.
module pid_tilt_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ptc_pkg::ANGLE_W-1:0]   in_measured_angle,
  input  logic [ptc_pkg::TIME_W-1:0]           in_elapsed_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ptc_pkg::DRIVE_W-1:0]   out_drive,
  output logic                                out_clamped
);
  import ptc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Program sequencer
  ptc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Arithmetic datapath
  ptc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_measured_angle (in_measured_angle),
    .in_elapsed_time   (in_elapsed_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive         (out_drive),
    .out_clamped       (out_clamped)
  );

  assign in_ready = ctrl.accept;

endmodule

@@ rtl/ptc_checker.sv @@
module ptc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ptc_pkg::DRIVE_W-1:0] out_drive,
  input logic                              out_clamped
);
  import ptc_pkg::*;

  // Drive never leaves the clamp range
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= DRIVE_MAX && out_drive >= DRIVE_MIN))
    else $error("drive outside +-1.0");

  // A clamped word sits exactly on a limit
  a_clamp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |-> (out_drive == DRIVE_MAX || out_drive == DRIVE_MIN))
    else $error("clamped drive not at a limit");

  // One word at a time: no accept in the cycle right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_clamped))
    else $error("stalled result changed");

endmodule

bind pid_tilt_controller ptc_checker u_ptc_checker (.*);
